[sv/tep_pkg.sv]
// Shared types and constants for the time-of-flight emission point core.
package tep_pkg;

   localparam int Axes     = 3;
   localparam int PosW     = 16;
   localparam int DiffW    = PosW + 1;
   localparam int MagW     = PosW;
   localparam int TimeW    = 48;
   localparam int DtW      = 34;
   localparam int SqW      = 2 * MagW;
   localparam int QW       = SqW + 2;
   localparam int ProdW    = DtW + MagW;
   localparam int FracPad  = 16;
   localparam int RadW     = QW + FracPad;
   localparam int RootW    = RadW / 2;
   localparam int RemW     = RootW + 3;
   localparam int DenW     = RootW + 4;
   localparam int LightSh  = 12;
   localparam int NumW     = ProdW + 2 + LightSh + 2;
   localparam int QuoW     = 18;
   localparam int VW       = 20;

   localparam logic [DtW-1:0] DtCap = DtW'(64'h2_0000_0000);
   localparam logic signed [VW-1:0] OutMax = VW'(32767);
   localparam logic signed [VW-1:0] OutMin = -VW'(32768);

   typedef struct packed {
      logic signed [PosW-1:0]  first_x;
      logic signed [PosW-1:0]  first_y;
      logic signed [PosW-1:0]  first_z;
      logic        [TimeW-1:0] first_time;
      logic signed [PosW-1:0]  second_x;
      logic signed [PosW-1:0]  second_y;
      logic signed [PosW-1:0]  second_z;
      logic        [TimeW-1:0] second_time;
   } tep_req_type;

   typedef struct packed {
      logic signed [PosW-1:0] point_x;
      logic signed [PosW-1:0] point_y;
      logic signed [PosW-1:0] point_z;
      logic                   coincident_hits;
      logic                   clipped;
   } tep_rsp_type;

   typedef struct packed {
      logic signed [DiffW-1:0] sum;
      logic                    neg;
      logic                    nz;
      logic        [ProdW-1:0] prod;
   } tep_lane_type;

   typedef struct packed {
      tep_lane_type [Axes-1:0] lane;
      logic                    coinc;
   } tep_side_type;

endpackage

[sv/tep_prep.sv]
// Front stages: hit ordering, differences, products and squared length.
module tep_prep import tep_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  tep_req_type       in_req,
   output logic              out_vld,
   output logic [QW-1:0]     out_q,
   output tep_side_type      out_side
);

   logic                    v0_ff, v1_ff, v2_ff, v3_ff;
   tep_req_type             req_ff;

   logic signed [DiffW-1:0] d_in   [Axes];
   logic signed [DiffW-1:0] d_ff   [Axes];
   logic signed [DiffW-1:0] s_in   [Axes];
   logic signed [DiffW-1:0] s_ff   [Axes];
   logic [DtW-1:0]          dt_in, dt_ff;
   logic                    c1_in, c1_ff;

   logic [SqW-1:0]          sq_in  [Axes];
   logic [SqW-1:0]          sq_ff  [Axes];
   tep_side_type            side2_in, side2_ff;

   logic [QW-1:0]           q_in, q_ff;
   tep_side_type            side3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= in_vld;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= in_req;
   end

   // stage 1: order by time, per-axis difference and sum
   always_comb begin
      logic signed [PosW-1:0] a [Axes];
      logic signed [PosW-1:0] b [Axes];
      logic signed [PosW-1:0] early, late;
      logic [TimeW-1:0]       dfull;
      logic                   a_first;
      a[0] = req_ff.first_x;
      a[1] = req_ff.first_y;
      a[2] = req_ff.first_z;
      b[0] = req_ff.second_x;
      b[1] = req_ff.second_y;
      b[2] = req_ff.second_z;
      a_first = req_ff.first_time < req_ff.second_time;
      c1_in = 1'b1;
      for (int i = 0; i < Axes; i++) begin
         early = a_first ? a[i] : b[i];
         late  = a_first ? b[i] : a[i];
         d_in[i] = {late[PosW-1], late} - {early[PosW-1], early};
         s_in[i] = {a[i][PosW-1], a[i]} + {b[i][PosW-1], b[i]};
         if (d_in[i] != '0) begin
            c1_in = 1'b0;
         end
      end
      dfull = (req_ff.first_time > req_ff.second_time) ?
              req_ff.first_time - req_ff.second_time :
              req_ff.second_time - req_ff.first_time;
      dt_in = (dfull > TimeW'(DtCap)) ? DtCap : dfull[DtW-1:0];
   end

   always_ff @(posedge clock) begin
      d_ff  <= d_in;
      s_ff  <= s_in;
      dt_ff <= dt_in;
      c1_ff <= c1_in;
   end

   // stage 2: magnitudes, squares and time products
   always_comb begin
      logic [DiffW-1:0] nd;
      logic [MagW-1:0]  mag;
      for (int i = 0; i < Axes; i++) begin
         nd  = -d_ff[i];
         mag = d_ff[i][DiffW-1] ? nd[MagW-1:0] : d_ff[i][MagW-1:0];
         sq_in[i] = mag * mag;
         side2_in.lane[i].prod = dt_ff * mag;
         side2_in.lane[i].sum  = s_ff[i];
         side2_in.lane[i].neg  = d_ff[i][DiffW-1];
         side2_in.lane[i].nz   = (d_ff[i] != '0);
      end
      side2_in.coinc = c1_ff;
   end

   always_ff @(posedge clock) begin
      sq_ff    <= sq_in;
      side2_ff <= side2_in;
   end

   // stage 3: squared length
   assign q_in = QW'(sq_ff[0]) + QW'(sq_ff[1]) + QW'(sq_ff[2]);

   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      side3_ff <= side2_ff;
   end

   assign out_vld  = v3_ff;
   assign out_q    = q_ff;
   assign out_side = side3_ff;

endmodule

[sv/tep_sqrt.sv]
// Pipelined integer square root of the scaled squared length, one bit per stage.
module tep_sqrt import tep_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  logic [QW-1:0]     in_q,
   input  tep_side_type      in_side,
   output logic              out_vld,
   output logic [RootW-1:0]  out_root,
   output tep_side_type      out_side
);

   logic               vld_ff  [RootW+1];
   logic [RadW-1:0]    rad_ff  [RootW+1];
   logic [RootW-1:0]   root_ff [RootW+1];
   logic [RemW-1:0]    rem_ff  [RootW+1];
   tep_side_type       side_ff [RootW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff[0]  <= {in_q, FracPad'(0)};
      root_ff[0] <= '0;
      rem_ff[0]  <= '0;
      side_ff[0] <= in_side;
   end

   for (genvar k = 0; k < RootW; k++) begin : g_step
      logic [RemW-1:0]  rem_sh, trial, rem_in;
      logic [RootW-1:0] root_in;
      logic             take;

      always_comb begin
         rem_sh  = {rem_ff[k][RemW-3:0], rad_ff[k][RadW-1 -: 2]};
         trial   = {1'b0, root_ff[k], 2'b01};
         take    = rem_sh >= trial;
         rem_in  = take ? rem_sh - trial : rem_sh;
         root_in = {root_ff[k][RootW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[k+1]  <= {rad_ff[k][RadW-3:0], 2'b00};
         root_ff[k+1] <= root_in;
         rem_ff[k+1]  <= rem_in;
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_vld  = vld_ff[RootW];
   assign out_root = root_ff[RootW];
   assign out_side = side_ff[RootW];

endmodule

[sv/tep_div.sv]
// One axis lane: shift quotient by restoring division, then rounding and saturation.
module tep_div import tep_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_vld,
   input  logic [RootW-1:0]        in_root,
   input  tep_lane_type            in_lane,
   input  logic                    in_coinc,
   output logic                    out_vld,
   output logic signed [PosW-1:0]  out_point,
   output logic                    out_sat,
   output logic                    out_coinc
);

   typedef struct packed {
      logic signed [DiffW-1:0] sum;
      logic                    neg;
      logic                    offs;
      logic                    coinc;
   } tail_type;

   logic               v1_ff, v2_ff;
   logic [NumW-1:0]    num_in, num1_ff, num2_ff;
   logic [DenW-1:0]    den_in, den1_ff, den2_ff;
   tail_type           tail_in, tail1_ff, tail2_ff;
   logic               big_in, big_ff [QuoW+1];

   logic               vld_ff  [QuoW+1];
   logic [NumW-1:0]    rem_ff  [QuoW+1];
   logic [DenW-1:0]    den_ff  [QuoW+1];
   logic [QuoW-1:0]    quo_ff  [QuoW+1];
   tail_type           tail_ff [QuoW+1];

   logic                    vo_ff;
   logic signed [PosW-1:0]  point_in, point_ff;
   logic                    sat_in, sat_ff;
   logic                    coinc_ff;

   // numerator 12288*dt*|d| + 5*L8, denominator 10*L8
   always_comb begin
      logic [ProdW+1:0] p3;
      p3      = (ProdW+2)'(in_lane.prod) + ((ProdW+2)'(in_lane.prod) << 1);
      num_in  = NumW'({p3, LightSh'(0)}) + NumW'(in_root) + (NumW'(in_root) << 2);
      den_in  = (DenW'(in_root) << 3) + (DenW'(in_root) << 1);
      tail_in.sum   = in_lane.sum;
      tail_in.neg   = in_lane.neg;
      tail_in.offs  = in_coinc | ~in_lane.nz;
      tail_in.coinc = in_coinc;
   end

   assign big_in = num1_ff >= NumW'({den1_ff, QuoW'(0)});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_vld;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      num1_ff  <= num_in;
      den1_ff  <= den_in;
      tail1_ff <= tail_in;
      num2_ff  <= num1_ff;
      den2_ff  <= den1_ff;
      tail2_ff <= tail1_ff;
   end

   always_comb begin
      vld_ff[0]  = v2_ff;
      rem_ff[0]  = num2_ff;
      den_ff[0]  = den2_ff;
      quo_ff[0]  = '0;
      tail_ff[0] = tail2_ff;
   end

   always_ff @(posedge clock) begin
      big_ff[0] <= big_in;
   end

   for (genvar j = 0; j < QuoW; j++) begin : g_step
      localparam int K = QuoW - 1 - j;
      logic [NumW-1:0] dsh, rem_in;
      logic            take;

      always_comb begin
         dsh    = NumW'(den_ff[j]) << K;
         take   = rem_ff[j] >= dsh;
         rem_in = take ? rem_ff[j] - dsh : rem_ff[j];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else begin
            vld_ff[j+1] <= vld_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j+1]  <= rem_in;
         den_ff[j+1]  <= den_ff[j];
         quo_ff[j+1]  <= {quo_ff[j][QuoW-2:0], take};
         tail_ff[j+1] <= tail_ff[j];
         big_ff[j+1]  <= big_ff[j];
      end
   end

   // apply shift, round half up, saturate
   always_comb begin
      logic [QuoW:0]          m2;
      logic signed [VW-1:0]   sx, v2, t, half;
      if (tail_ff[QuoW].offs) begin
         m2 = '0;
      end else if (big_ff[QuoW]) begin
         m2 = (QuoW+1)'(1) << QuoW;
      end else begin
         m2 = {1'b0, quo_ff[QuoW]};
      end
      sx   = VW'(tail_ff[QuoW].sum);
      v2   = tail_ff[QuoW].neg ? sx + VW'(m2) : sx - VW'(m2);
      t    = v2 + VW'(1);
      half = t >>> 1;
      sat_in = 1'b1;
      if (half > OutMax) begin
         point_in = OutMax[PosW-1:0];
      end else if (half < OutMin) begin
         point_in = OutMin[PosW-1:0];
      end else begin
         point_in = half[PosW-1:0];
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= vld_ff[QuoW];
      end
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
      sat_ff   <= sat_in;
      coinc_ff <= tail_ff[QuoW].coinc;
   end

   assign out_vld   = vo_ff;
   assign out_point = point_ff;
   assign out_sat   = sat_ff;
   assign out_coinc = coinc_ff;

endmodule

[sv/tof_emission_point_core.sv]
// Top level of the time-of-flight emission point core.
//
//   channel   ports                         direction   handshake
//   request   start, busy, req_data         in          start && !busy
//   response  rsp_strobe, rsp_data          out         rsp_strobe, one cycle
//
// One transaction enters per clock; busy is never raised.
// The path from start to rsp_strobe runs through 4 front stages, 26 square
// root stages (an input stage, then one root bit each), 20 division stages (one quotient bit each
// plus two setup stages) and one output stage.
// Reset clears all valid bits; transactions in flight are dropped.
// The receiver takes every result in the cycle it is shown.
module tof_emission_point_core import tep_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  tep_req_type  req_data,
   output logic         rsp_strobe,
   output tep_rsp_type  rsp_data
);

   logic                    pv;
   logic [QW-1:0]           pq;
   tep_side_type            pside;
   logic                    sv;
   logic [RootW-1:0]        sroot;
   tep_side_type            sside;

   logic                    lv     [Axes];
   logic signed [PosW-1:0]  lpoint [Axes];
   logic                    lsat   [Axes];
   logic                    lcoinc [Axes];

   assign busy = 1'b0;

   tep_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (start),
      .in_req   (req_data),
      .out_vld  (pv),
      .out_q    (pq),
      .out_side (pside)
   );

   tep_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (pv),
      .in_q     (pq),
      .in_side  (pside),
      .out_vld  (sv),
      .out_root (sroot),
      .out_side (sside)
   );

   for (genvar i = 0; i < Axes; i++) begin : g_lane
      tep_div u_div (
         .clock     (clock),
         .reset     (reset),
         .in_vld    (sv),
         .in_root   (sroot),
         .in_lane   (sside.lane[i]),
         .in_coinc  (sside.coinc),
         .out_vld   (lv[i]),
         .out_point (lpoint[i]),
         .out_sat   (lsat[i]),
         .out_coinc (lcoinc[i])
      );
   end

   assign rsp_strobe               = lv[0];
   assign rsp_data.point_x         = lpoint[0];
   assign rsp_data.point_y         = lpoint[1];
   assign rsp_data.point_z         = lpoint[2];
   assign rsp_data.coincident_hits = lcoinc[0];
   assign rsp_data.clipped         = lsat[0] | lsat[1] | lsat[2];

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      lv[0] == lv[1] && lv[0] == lv[2])
      else $error("axis lanes out of step");

   a_coinc_no_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.coincident_hits |-> !rsp_data.clipped)
      else $error("coincident hits reported as clipped");

   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.clipped |->
         (rsp_data.point_x == 16'sh7fff || rsp_data.point_x == -16'sh8000 ||
          rsp_data.point_y == 16'sh7fff || rsp_data.point_y == -16'sh8000 ||
          rsp_data.point_z == 16'sh7fff || rsp_data.point_z == -16'sh8000))
      else $error("clipped without a coordinate at a limit");

endmodule
